[src/ilp_pkg.sv]
// shared types, codes and tables of the integer literal parser
package ilp_pkg;

  localparam int ILP_QUEUE_DEPTH = 2;

  localparam logic [2:0] CLS_DEC   = 3'd0;
  localparam logic [2:0] CLS_OTHER = 3'd4;
  localparam logic [2:0] CLS_NONE  = 3'd5;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [1:0] SIZE_NONE  = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_INT   = 2'd2;
  localparam logic [1:0] SIZE_LONG  = 2'd3;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_BODY   = 2'd2;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LO    = 8'h6f;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LL    = 8'h6c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [6:0] CNT_MAX          = 7'd127;
  localparam logic [6:0] CAP_LONG_DEC_NEG = 7'd19;

  typedef struct packed {
    logic [3:0] digit;
    logic       is_hex;
    logic       is_u;
    logic       is_s;
    logic       is_l;
    logic       is_zero;
    logic       is_plus;
    logic       is_minus;
    logic       pfx_b;
    logic       pfx_o;
    logic       pfx_x;
    logic [2:0] token_class;
    logic       last_char;
  } ilp_item_t;

  function automatic logic [6:0] digit_cap(input logic [1:0] size, input logic [1:0] radix);
    logic [6:0] cap;
    cap = 7'd0;
    case (size)
      SIZE_SHORT: begin
        case (radix)
          RADIX_DEC: cap = 7'd5;
          RADIX_BIN: cap = 7'd16;
          RADIX_OCT: cap = 7'd6;
          default:   cap = 7'd4;
        endcase
      end
      SIZE_INT: begin
        case (radix)
          RADIX_DEC: cap = 7'd10;
          RADIX_BIN: cap = 7'd32;
          RADIX_OCT: cap = 7'd11;
          default:   cap = 7'd8;
        endcase
      end
      SIZE_LONG: begin
        case (radix)
          RADIX_DEC: cap = 7'd20;
          RADIX_BIN: cap = 7'd64;
          RADIX_OCT: cap = 7'd22;
          default:   cap = 7'd16;
        endcase
      end
      default: cap = 7'd0;
    endcase
    return cap;
  endfunction

endpackage

[src/ilp_char_if.sv]
// character channel: one token byte per transfer
interface ilp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic [2:0] token_class;
  logic       last_char;

  modport source(output valid, text_char, token_class, last_char, input ready);
  modport sink(input valid, text_char, token_class, last_char, output ready);
endinterface

[src/ilp_lit_if.sv]
// literal channel: one parsed value per transfer
interface ilp_lit_if;
  logic        valid;
  logic        ready;
  logic [63:0] literal_value;
  logic [1:0]  size_code;
  logic        is_unsigned;

  modport source(output valid, literal_value, size_code, is_unsigned, input ready);
  modport sink(input valid, literal_value, size_code, is_unsigned, output ready);
endinterface

[src/ilp_front.sv]
// front stage: takes characters and registers their decoded class bits
module ilp_front (
  input  logic              clk,
  input  logic              rst,
  ilp_char_if.sink          chars,
  output logic              item_valid,
  input  logic              item_ready,
  output ilp_pkg::ilp_item_t item
);
  import ilp_pkg::*;

  ilp_item_t  dec;
  logic [7:0] lc;
  logic       is_num;
  logic       is_let;

  always_comb begin
    lc     = chars.text_char | CASE_BIT;
    is_num = chars.text_char inside {[CH_0:CH_9]};
    is_let = lc inside {[CH_LA:CH_LF]};
    dec.digit       = is_num ? chars.text_char[3:0] : lc[3:0] + 4'd9;
    dec.is_hex      = is_num || is_let;
    dec.is_u        = (lc == CH_LU);
    dec.is_s        = (lc == CH_LS);
    dec.is_l        = (lc == CH_LL);
    dec.is_zero     = (chars.text_char == CH_0);
    dec.is_plus     = (chars.text_char == CH_PLUS);
    dec.is_minus    = (chars.text_char == CH_MINUS);
    dec.pfx_b       = (lc == CH_LB);
    dec.pfx_o       = (lc == CH_LO);
    dec.pfx_x       = (lc == CH_LX);
    dec.token_class = chars.token_class;
    dec.last_char   = chars.last_char;
  end

  assign chars.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.ready) begin
      item_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item <= dec;
    end
  end
endmodule

[src/ilp_queue.sv]
// short queue of decoded characters between front and back
module ilp_queue #(
  parameter int Depth = ilp_pkg::ILP_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  ilp_pkg::ilp_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ilp_pkg::ilp_item_t pop_item
);
  import ilp_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  ilp_item_t         mem [Depth];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end
endmodule

[src/ilp_back.sv]
// back stage: prefix, sign, digit and suffix handling, result register
module ilp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ilp_pkg::ilp_item_t item,
  ilp_lit_if.source          literal
);
  import ilp_pkg::*;

  logic [63:0] acc, acc_next;
  logic [6:0]  cnt, cnt_next;
  logic [1:0]  pos, pos_next;
  logic [1:0]  radix, radix_next;
  logic        neg, neg_next;
  logic        uns, uns_next;
  logic [1:0]  size, size_next;
  logic        sfx, sfx_next;
  logic        err, err_next;
  logic        body;
  logic        digit_ok;
  logic [63:0] prod;
  logic [63:0] dterm;
  logic [6:0]  cap;
  logic        bad;
  logic        take;

  assign item_ready = !literal.valid || literal.ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    acc_next   = acc;
    cnt_next   = cnt;
    radix_next = radix;
    neg_next   = neg;
    uns_next   = uns;
    size_next  = size;
    sfx_next   = sfx;
    err_next   = err;
    body       = 1'b0;
    pos_next   = (pos != POS_BODY) ? pos + 2'd1 : pos;

    if (!err) begin
      if (pos == POS_FIRST) begin
        if (item.token_class >= CLS_NONE) begin
          err_next = 1'b1;
        end else begin
          radix_next = (item.token_class < CLS_OTHER) ? item.token_class[1:0] : RADIX_DEC;
          if (item.token_class == CLS_DEC && (item.is_plus || item.is_minus)) begin
            neg_next = item.is_minus;
          end else if (radix_next != RADIX_DEC) begin
            if (!item.is_zero || item.last_char) err_next = 1'b1;
            uns_next = 1'b1;
          end else begin
            body = 1'b1;
          end
        end
      end else if (pos == POS_SECOND && radix != RADIX_DEC) begin
        case (radix)
          RADIX_BIN: if (!item.pfx_b) err_next = 1'b1;
          RADIX_OCT: if (!item.pfx_o) err_next = 1'b1;
          default:   if (!item.pfx_x) err_next = 1'b1;
        endcase
      end else begin
        body = 1'b1;
      end
    end

    case (radix_next)
      RADIX_DEC: digit_ok = (item.digit < 4'd10);
      RADIX_BIN: digit_ok = (item.digit < 4'd2);
      RADIX_OCT: digit_ok = (item.digit < 4'd8);
      default:   digit_ok = 1'b1;
    endcase

    case (radix_next)
      RADIX_DEC: prod = {acc[60:0], 3'b000} + {acc[62:0], 1'b0};
      RADIX_BIN: prod = {acc[62:0], 1'b0};
      RADIX_OCT: prod = {acc[60:0], 3'b000};
      default:   prod = {acc[59:0], 4'b0000};
    endcase
    // accumulate negative literals already negated
    dterm = neg ? 64'd0 - {60'd0, item.digit} : {60'd0, item.digit};

    if (body) begin
      if (item.is_u) begin
        if (uns) err_next = 1'b1;
        uns_next = 1'b1;
        sfx_next = 1'b1;
      end else if (item.is_s || item.is_l) begin
        if (size != SIZE_INT) err_next = 1'b1;
        size_next = item.is_s ? SIZE_SHORT : SIZE_LONG;
        sfx_next  = 1'b1;
      end else if (sfx || !item.is_hex || !digit_ok) begin
        err_next = 1'b1;
      end else begin
        acc_next = prod + dterm;
        if (cnt != CNT_MAX) cnt_next = cnt + 7'd1;
      end
    end

    cap = digit_cap(size_next, radix_next);
    if (size_next == SIZE_LONG && radix_next == RADIX_DEC && neg_next) cap = CAP_LONG_DEC_NEG;
    bad = err_next || size_next == SIZE_NONE || cnt_next > cap;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last_char)) begin
      acc   <= '0;
      cnt   <= '0;
      pos   <= POS_FIRST;
      radix <= RADIX_DEC;
      neg   <= 1'b0;
      uns   <= 1'b0;
      size  <= SIZE_INT;
      sfx   <= 1'b0;
      err   <= 1'b0;
    end else if (take) begin
      acc   <= acc_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
      radix <= radix_next;
      neg   <= neg_next;
      uns   <= uns_next;
      size  <= size_next;
      sfx   <= sfx_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      literal.valid <= 1'b0;
    end else if (take && item.last_char) begin
      literal.valid <= 1'b1;
    end else if (literal.ready) begin
      literal.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_char) begin
      literal.literal_value <= bad ? 64'd0 : acc_next;
      literal.size_code     <= bad ? SIZE_NONE : size_next;
      literal.is_unsigned   <= bad ? 1'b0 : uns_next;
    end
  end
endmodule

[src/integer_literal_parser.sv]
// integer literal parser top level: front decode, queue, back accumulate
//
//   channel   modport   transfers
//   chars     sink      one token byte, its class and the end mark
//   literal   source    one value, size code and unsigned flag per token
//
// one character per cycle sustained while the back stage does not stall;
// each character is decoded in the front register, waits in the queue and
// is applied by the back stage; the last byte of a token registers its result
// the back stage stalls only while the result register is full and not taken
// reset clears the parse state and empties all stages
module integer_literal_parser #(
  parameter int QueueDepth = ilp_pkg::ILP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  ilp_char_if.sink  chars,
  ilp_lit_if.source literal
);
  import ilp_pkg::*;

  logic      f_valid;
  logic      f_ready;
  ilp_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  ilp_item_t q_item;

  ilp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .item_valid(f_valid),
    .item_ready(f_ready),
    .item      (f_item)
  );

  ilp_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_item (f_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  ilp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(q_valid),
    .item_ready(q_ready),
    .item      (q_item),
    .literal   (literal)
  );
endmodule

[src/ilp_checker.sv]
// port checks of the integer literal parser and their bind
module ilp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value,
  input logic [1:0]  out_size,
  input logic        out_uns
);
  import ilp_pkg::*;

  logic [3:0] pending;
  logic       last_xfer;
  logic       out_xfer;

  assign last_xfer = in_valid && in_ready && in_last;
  assign out_xfer  = out_valid && out_ready;

  // tokens ended but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_xfer && !out_xfer) begin
      pending <= pending + 4'd1;
    end else if (out_xfer && !last_xfer) begin
      pending <= pending - 4'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pending != 4'd0)
    else $error("result transfer without an ended token");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_size == SIZE_NONE |-> out_value == 64'd0 && !out_uns)
    else $error("error result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_size)
      && $stable(out_uns))
    else $error("stalled result changed");
endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (chars.valid),
  .in_ready (chars.ready),
  .in_last  (chars.last_char),
  .out_valid(literal.valid),
  .out_ready(literal.ready),
  .out_value(literal.literal_value),
  .out_size (literal.size_code),
  .out_uns  (literal.is_unsigned)
);

[bench/integer_literal_parser_tb.sv]
// self-checking testbench for the integer literal parser: token stimulus, prediction and checking
module integer_literal_parser_tb;
  import ilp_pkg::*;

  localparam logic [2:0] TOK_BIN = 3'd1;
  localparam logic [2:0] TOK_OCT = 3'd2;
  localparam logic [2:0] TOK_HEX = 3'd3;

  localparam int CHAR_TARGET    = 1450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [7:0] text;
    logic [2:0] cls;
    logic       last;
  } char_item_t;

  class literal_book;
    typedef struct {
      logic [63:0] value;
      logic [1:0]  size;
      logic        uns;
    } literal_t;

    localparam int MAX_REPORTS = 10;

    literal_t    expected_q[$];
    logic [63:0] acc;
    logic [6:0]  ndig;
    logic [1:0]  pos;
    logic [1:0]  radix;
    logic [1:0]  size;
    logic        neg;
    logic        uns;
    logic        sfx;
    logic        err;
    int          mismatches;
    int          checked;
    int          tokens;
    int          chars_in;
    int          by_size[4];

    function new();
      clear();
    endfunction

    function void clear();
      acc   = '0;
      ndig  = '0;
      pos   = POS_FIRST;
      radix = RADIX_DEC;
      size  = SIZE_INT;
      neg   = 1'b0;
      uns   = 1'b0;
      sfx   = 1'b0;
      err   = 1'b0;
    endfunction

    static function logic [7:0] prefix_of(logic [1:0] r);
      case (r)
        RADIX_BIN: return CH_LB;
        RADIX_OCT: return CH_LO;
        RADIX_HEX: return CH_LX;
        default:   return 8'h00;
      endcase
    endfunction

    static function logic [63:0] base_of(logic [1:0] r);
      case (r)
        RADIX_BIN: return 64'd2;
        RADIX_OCT: return 64'd8;
        RADIX_HEX: return 64'd16;
        default:   return 64'd10;
      endcase
    endfunction

    // longest digit string allowed for a size and radix
    static function logic [6:0] limit_of(logic [1:0] sz, logic [1:0] r, logic ng);
      logic [6:0] lim;
      case (sz)
        SIZE_SHORT: lim = (r == RADIX_DEC) ? 7'd5 : (r == RADIX_BIN) ? 7'd16 :
                          (r == RADIX_OCT) ? 7'd6 : 7'd4;
        SIZE_INT:   lim = (r == RADIX_DEC) ? 7'd10 : (r == RADIX_BIN) ? 7'd32 :
                          (r == RADIX_OCT) ? 7'd11 : 7'd8;
        SIZE_LONG:  lim = (r == RADIX_DEC) ? (ng ? CAP_LONG_DEC_NEG : 7'd20) :
                          (r == RADIX_BIN) ? 7'd64 : (r == RADIX_OCT) ? 7'd22 : 7'd16;
        default:    lim = 7'd0;
      endcase
      return lim;
    endfunction

    // suffix letters, then digits
    function void take_body(logic [7:0] c);
      logic [7:0]  lc;
      logic [63:0] d;
      logic [63:0] base;
      lc   = c | CASE_BIT;
      base = base_of(radix);
      if (lc == CH_LU) begin
        if (uns) err = 1'b1;
        uns = 1'b1;
        sfx = 1'b1;
        return;
      end
      if (lc == CH_LS || lc == CH_LL) begin
        if (size != SIZE_INT) err = 1'b1;
        size = (lc == CH_LS) ? SIZE_SHORT : SIZE_LONG;
        sfx  = 1'b1;
        return;
      end
      if (sfx) begin
        err = 1'b1;
        return;
      end
      if (c >= CH_0 && c <= CH_9) begin
        d = 64'(c - CH_0);
      end else if (lc >= CH_LA && lc <= CH_LF) begin
        d = 64'(lc - CH_LA) + 64'd10;
      end else begin
        err = 1'b1;
        return;
      end
      if (d >= base) begin
        err = 1'b1;
        return;
      end
      acc = acc * base + d;
      if (ndig != CNT_MAX) ndig = ndig + 7'd1;
    endfunction

    function void note_char(logic [7:0] c, logic [2:0] cls, logic last);
      literal_t r;
      chars_in++;
      if (!err) begin
        if (pos == POS_FIRST) begin
          if (cls >= CLS_NONE) begin
            err = 1'b1;
          end else begin
            radix = (cls == CLS_OTHER) ? RADIX_DEC : cls[1:0];
            if (cls == CLS_DEC && (c == CH_MINUS || c == CH_PLUS)) begin
              neg = (c == CH_MINUS);
            end else if (radix != RADIX_DEC) begin
              if (c != CH_0 || last) err = 1'b1;
              uns = 1'b1;
            end else begin
              take_body(c);
            end
          end
        end else if (pos == POS_SECOND && radix != RADIX_DEC) begin
          if ((c | CASE_BIT) != prefix_of(radix)) err = 1'b1;
        end else begin
          take_body(c);
        end
      end
      if (pos != POS_BODY) pos = pos + 2'd1;
      if (last) begin
        if (err || size == SIZE_NONE || ndig > limit_of(size, radix, neg)) begin
          r = '{64'd0, SIZE_NONE, 1'b0};
        end else begin
          r = '{neg ? 64'd0 - acc : acc, size, uns};
        end
        expected_q.push_back(r);
        tokens++;
        clear();
      end
    endfunction

    function void check_literal(logic [63:0] value, logic [1:0] sz, logic u);
      literal_t e;
      checked++;
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected literal transfer: value %h size %0d unsigned %b", value, sz, u);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      by_size[e.size]++;
      if (value !== e.value || sz !== e.size || u !== e.uns) begin
        if (mismatches < MAX_REPORTS)
          $display("literal mismatch: expected value %h size %0d unsigned %b, got %h %0d %b",
                   e.value, e.size, e.uns, value, sz, u);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ilp_char_if chars();
  ilp_lit_if  literal();

  integer_literal_parser dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .literal (literal)
  );

  literal_book book = new();
  char_item_t  token_q[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          stuck = 0;

  always #5 clk = ~clk;

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    literal.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        literal.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        literal.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stuck <= 0;
    end else begin
      if (literal.valid && literal.ready)
        book.check_literal(literal.literal_value, literal.size_code, literal.is_unsigned);
      if ((chars.valid && chars.ready) || (literal.valid && literal.ready)) begin
        stuck <= 0;
      end else if (stuck == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("integer_literal_parser_tb: done, errors");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  function automatic logic [7:0] case_flip();
    return $urandom_range(0, 1) ? CASE_BIT : 8'h00;
  endfunction

  task automatic put_char(input char_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    chars.valid       <= 1'b1;
    chars.text_char   <= it.text;
    chars.token_class <= it.cls;
    chars.last_char   <= it.last;
    do @(posedge clk); while (!chars.ready);
    book.note_char(it.text, it.cls, it.last);
  endtask

  // later bytes carry a class that must be ignored
  task automatic send_text(input string s, input logic [2:0] cls);
    char_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it = '{8'(s[i]), (i == 0) ? cls : CLS_NONE, i == s.len() - 1};
      put_char(it);
    end
  endtask

  task automatic settle();
    chars.valid <= 1'b0;
    do @(posedge clk); while (book.expected_q.size() != 0);
  endtask

  // one token: mostly well formed with random content, some broken or noise
  function automatic void make_token();
    logic [7:0]  t[$];
    logic [2:0]  cls;
    logic [1:0]  rdx;
    logic [1:0]  sz;
    logic [63:0] base;
    logic [7:0]  sz_char;
    logic [7:0]  u_char;
    logic        ng;
    logic        want_u;
    logic        want_sz;
    int          pick;
    int          n;
    int          lim;
    int          dmode;
    int          d;
    token_q.delete();
    ng   = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      cls = 3'($urandom_range(0, 5));
      repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (pick < 38) cls = CLS_DEC;
      else if (pick < 53) cls = TOK_BIN;
      else if (pick < 68) cls = TOK_OCT;
      else if (pick < 86) cls = TOK_HEX;
      else if (pick < 96) cls = CLS_OTHER;
      else cls = CLS_NONE;
      rdx = (cls <= TOK_HEX) ? cls[1:0] : RADIX_DEC;
      if (cls == CLS_DEC && $urandom_range(0, 99) < 35) begin
        ng = 1'($urandom_range(0, 1));
        t.push_back(ng ? CH_MINUS : CH_PLUS);
      end
      if (rdx != RADIX_DEC) begin
        t.push_back(CH_0);
        t.push_back(literal_book::prefix_of(rdx) ^ case_flip());
      end
      pick = $urandom_range(0, 99);
      sz   = (pick < 20) ? SIZE_SHORT : (pick < 55) ? SIZE_INT : SIZE_LONG;
      lim  = literal_book::limit_of(sz, rdx, ng);
      pick = $urandom_range(0, 99);
      if (pick < 20) n = $urandom_range(0, 3);
      else if (pick < 55) n = $urandom_range(1, lim);
      else if (pick < 80) n = lim;
      else if (pick < 97) n = lim + 1;
      else n = $urandom_range(120, 135);
      base  = literal_book::base_of(rdx);
      dmode = $urandom_range(0, 99);
      for (int i = 0; i < n; i++) begin
        if (dmode < 15) d = int'(base) - 1;
        else if (dmode < 22) d = 0;
        else d = $urandom_range(0, int'(base) - 1);
        t.push_back((d < 10) ? 8'(CH_0 + d) : (8'(CH_LA + d - 10) ^ case_flip()));
      end
      want_u  = $urandom_range(0, 99) < ((rdx == RADIX_DEC) ? 40 : 4);
      want_sz = (sz != SIZE_INT);
      sz_char = ((sz == SIZE_SHORT) ? CH_LS : CH_LL) ^ case_flip();
      u_char  = CH_LU ^ case_flip();
      if (want_u && want_sz && $urandom_range(0, 1)) begin
        t.push_back(sz_char);
        t.push_back(u_char);
      end else begin
        if (want_u) t.push_back(u_char);
        if (want_sz) t.push_back(sz_char);
      end
      if ($urandom_range(0, 99) < 10) begin
        case ($urandom_range(0, 3))
          0: if (t.size() > 0) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
          1: t.insert($urandom_range(0, t.size()), 8'($urandom_range(0, 255)));
          2: begin
            case ($urandom_range(0, 2))
              0: t.push_back(CH_LU ^ case_flip());
              1: t.push_back(CH_LS ^ case_flip());
              default: t.push_back(CH_LL ^ case_flip());
            endcase
          end
          default: t.push_back(8'(CH_0 + $urandom_range(0, 9)));
        endcase
      end
    end
    if (t.size() == 0) t.push_back(8'(CH_0 + $urandom_range(0, 9)));
    foreach (t[i])
      token_q.push_back('{t[i], (i == 0) ? cls : 3'($urandom_range(0, 5)), i == t.size() - 1});
  endfunction

  task automatic random_tokens(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      make_token();
      foreach (token_q[i]) put_char(token_q[i]);
      sent += token_q.size();
    end
  endtask

  initial begin
    chars.valid       = 1'b0;
    chars.text_char   = 8'h00;
    chars.token_class = CLS_DEC;
    chars.last_char   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bare prefix, one-byte prefix, signs, suffixes, classes, byte extremes
    send_text("0x", TOK_HEX);
    send_text("0", TOK_BIN);
    send_text("0B1l", TOK_BIN);
    send_text("0o7u", TOK_OCT);
    send_text("-9", CLS_DEC);
    send_text("+7", CLS_DEC);
    send_text("-", CLS_DEC);
    send_text("12uS", CLS_OTHER);
    send_text("7", CLS_NONE);
    send_text("1ll", CLS_DEC);
    send_text("1u2", CLS_DEC);
    put_char('{8'hff, CLS_DEC, 1'b1});
    put_char('{8'h00, CLS_DEC, 1'b1});
    settle();

    send_idle_pct = 22;
    recv_idle_pct = 62;
    random_tokens(CHAR_TARGET / 3);
    settle();

    send_idle_pct = 62;
    recv_idle_pct = 22;
    random_tokens(CHAR_TARGET / 3);
    settle();

    // no idling; a long receiver hold-off backs the block up first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    random_tokens(CHAR_TARGET / 3);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("parsed %0d tokens from %0d characters, %0d literal transfers checked",
             book.tokens, book.chars_in, book.checked);
    $display("results by size none/short/int/long: %0d/%0d/%0d/%0d, mismatches: %0d",
             book.by_size[0], book.by_size[1], book.by_size[2], book.by_size[3],
             book.mismatches);
    if (book.mismatches == 0 && book.expected_q.size() == 0) begin
      $display("integer_literal_parser_tb: done, clean");
    end else begin
      $display("integer_literal_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
